// ===== hw/rtl/lpars_pkg.sv =====
// Shared constants, types and arithmetic helpers for the progression-add
// range-sum tree. No dependencies; used by the top level by scoped names.

package lpars_pkg;

	// Element count; must be a power of two so that the tree is perfect.
	localparam int N_ELEMS = 1024;
	localparam int LOG_N   = $clog2(N_ELEMS);

	// Node index into the sum store (nodes 1 .. 2N-1, leaves at N .. 2N-1).
	localparam int NA_W  = LOG_N + 1;
	// Node index into the pending store (internal nodes 1 .. N-1).
	localparam int LA_W  = LOG_N;
	// Half-open boundaries in leaf numbering reach 2N, so one bit more.
	localparam int BND_W = LOG_N + 2;
	// Tree height counter; heights run from 0 at the leaves up to LOG_N at the root.
	localparam int LVL_W = $clog2(LOG_N + 2);

	localparam int FUNC_W = 2;
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 64;
	localparam int CNT_W  = 32;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	typedef struct packed {
		logic [SUM_W-1:0] start;
		logic [CNT_W-1:0] count;
	} lazy_t;

	// Sum of the progression a, a+d, a+2d, ... over a node of height h,
	// that is 2^h elements: a*2^h + d*2^(h-1)*(2^h-1), by shifts only.
	function automatic logic [SUM_W-1:0] prog_sum(
		input logic [SUM_W-1:0] a,
		input logic [CNT_W-1:0] d,
		input logic [LVL_W-1:0] h
	);
		logic [SUM_W-1:0] d64;
		logic [SUM_W-1:0] tri_sum;
		d64 = {{(SUM_W-CNT_W){1'b0}}, d};
		if (h == '0) begin
			tri_sum = '0;
		end else begin
			tri_sum = ((d64 << h) - d64) << (h - LVL_W'(1));
		end
		return (a << h) + tri_sum;
	endfunction

endpackage

// ===== hw/rtl/lpars_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.

module lpars_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/lazy_progression_add_range_sum.sv =====
// Top level of the progression-add range-sum tree: sequencer and two stores.
// Depends on lpars_pkg (constants, lazy_t, prog_sum) and lpars_ram.
//
// One input channel (in_valid / in_stall) carries an operation: a point load,
// a progression add over a range or a range-sum query. One output channel
// (out_valid / out_stall) carries one range_sum per query; loads and adds give
// no result. A transfer happens on a rising edge with valid high and stall low.
// The tree lives in two synchronous RAMs: node sums (2N x 64) and pending
// progressions (N x 96). An operation pushes pending work down the two boundary
// paths, covers the range with at most two nodes per level and, for loads and
// adds, recomputes sums back up the paths. An ignored code or an empty add is
// taken without a walk and an empty query goes straight to its result; any
// other item holds in_stall high for the walk. Each path level is skipped,
// visited with nothing pending or pushed down, and recomputed on the way up;
// each covering node is read and then updated. A query's result enters the
// output register from the done state after its walk; the next transfer is
// taken while it waits, and a query that finishes while the register is still
// full holds until the receiver takes the earlier result. After reset both
// RAMs are cleared, one entry per cycle, with in_stall high.

module lazy_progression_add_range_sum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lpars_pkg::FUNC_W-1:0]        func,
	input  logic [lpars_pkg::IDX_W-1:0]         left_index,
	input  logic [lpars_pkg::IDX_W-1:0]         right_index,
	input  logic signed [lpars_pkg::VAL_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lpars_pkg::SUM_W-1:0]  range_sum
);

	localparam int NA_W  = lpars_pkg::NA_W;
	localparam int LA_W  = lpars_pkg::LA_W;
	localparam int BND_W = lpars_pkg::BND_W;
	localparam int LVL_W = lpars_pkg::LVL_W;
	localparam int SUM_W = lpars_pkg::SUM_W;
	localparam int CNT_W = lpars_pkg::CNT_W;
	localparam int VAL_W = lpars_pkg::VAL_W;

	// Sequencer states.
	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_PSEL = 4'd2;
	localparam logic [3:0] ST_P0   = 4'd3;
	localparam logic [3:0] ST_P1   = 4'd4;
	localparam logic [3:0] ST_P2   = 4'd5;
	localparam logic [3:0] ST_P3   = 4'd6;
	localparam logic [3:0] ST_CSEL = 4'd7;
	localparam logic [3:0] ST_C0   = 4'd8;
	localparam logic [3:0] ST_C1   = 4'd9;
	localparam logic [3:0] ST_USEL = 4'd10;
	localparam logic [3:0] ST_U0   = 4'd11;
	localparam logic [3:0] ST_U1   = 4'd12;
	localparam logic [3:0] ST_U2   = 4'd13;
	localparam logic [3:0] ST_DONE = 4'd14;

	// Control state.
	logic [3:0]       state_q;
	logic             side_q;       // boundary path in use: left or right
	logic [LVL_W-1:0] lvl_q;        // height of the node being visited
	logic             step_done_q;  // the node at this level and side is finished
	logic [NA_W-1:0]  clr_q;
	logic             out_valid_q;
	logic             out_load;     // a finished query enters the output register

	// Operation payload and working registers.
	logic [lpars_pkg::FUNC_W-1:0] func_q;
	logic [BND_W-1:0]             ql_q;
	logic [SUM_W-1:0]             value_q;
	logic [BND_W-1:0]             l0_q;
	logic [BND_W-1:0]             r0_q;
	logic [BND_W-1:0]             l_q;
	logic [BND_W-1:0]             r_q;
	logic [NA_W-1:0]              node_q;
	logic [SUM_W-1:0]             a_q;
	logic [CNT_W-1:0]             d_q;
	logic [SUM_W-1:0]             ar_q;
	logic [SUM_W-1:0]             acc_q;
	logic [SUM_W-1:0]             sl_q;
	logic [SUM_W-1:0]             range_sum_q;

	// RAM ports.
	logic                 sum_we;
	logic [NA_W-1:0]      sum_waddr;
	logic [SUM_W-1:0]     sum_wdata;
	logic [NA_W-1:0]      sum_raddr;
	logic [SUM_W-1:0]     sum_rdata;
	logic                 lz_we;
	logic [LA_W-1:0]      lz_waddr;
	lpars_pkg::lazy_t     lz_wdata;
	logic [LA_W-1:0]      lz_raddr;
	lpars_pkg::lazy_t     lz_rdata;

	// Request decode.
	logic [BND_W-1:0] last_idx;
	logic [BND_W-1:0] li_ext;
	logic [BND_W-1:0] ri_ext;
	logic [BND_W-1:0] ri_clamped;
	logic             li_ok;
	logic             range_ok;

	// Path walking.
	logic [BND_W-1:0] path_bound;
	logic [BND_W-1:0] path_src;
	logic [BND_W-1:0] path_mask;
	logic [BND_W-1:0] path_shifted;
	logic             path_cond;
	logic [NA_W-1:0]  path_node;
	logic [NA_W-1:0]  child_l;
	logic [NA_W-1:0]  child_r;
	logic [LVL_W-1:0] child_h;
	logic [BND_W-1:0] r_m1;
	logic             lz_zero;

	// Canonical node arithmetic.
	logic [BND_W-1:0] node_lo;
	logic [BND_W-1:0] node_off;
	logic [SUM_W-1:0] a_add;

	assign last_idx   = BND_W'(lpars_pkg::N_ELEMS - 1);
	assign li_ext     = BND_W'(left_index);
	assign ri_ext     = BND_W'(right_index);
	assign ri_clamped = (ri_ext > last_idx) ? last_idx : ri_ext;
	assign li_ok      = (li_ext <= last_idx);
	assign range_ok   = li_ok && (li_ext <= ri_clamped);

	// Node on the chosen boundary path at height lvl_q, and whether the path
	// boundary is unaligned there, so that the node straddles the range edge.
	assign path_bound   = side_q ? r0_q : l0_q;
	assign path_src     = side_q ? (r0_q - BND_W'(1)) : l0_q;
	assign path_mask    = (BND_W'(1) << lvl_q) - BND_W'(1);
	assign path_cond    = (path_bound & path_mask) != '0;
	assign path_shifted = path_src >> lvl_q;
	assign path_node    = path_shifted[NA_W-1:0];

	assign child_l = {node_q[NA_W-2:0], 1'b0};
	assign child_r = {node_q[NA_W-2:0], 1'b1};
	assign child_h = lvl_q - LVL_W'(1);
	assign r_m1    = r_q - BND_W'(1);
	assign lz_zero = (lz_rdata.start == '0) && (lz_rdata.count == '0);

	// Leftmost element under a canonical node, and the progression value there.
	assign node_lo  = (BND_W'(node_q) << lvl_q) - BND_W'(lpars_pkg::N_ELEMS);
	assign node_off = node_lo - ql_q;
	assign a_add    = value_q + SUM_W'(node_off);

	// The output register takes a new result when it is empty or being emptied.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Read addresses.
	always_comb begin
		sum_raddr = '0;
		lz_raddr  = '0;
		case (state_q)
			ST_P0: begin
				lz_raddr = node_q[LA_W-1:0];
			end
			ST_P1: begin
				sum_raddr = child_l;
				lz_raddr  = child_l[LA_W-1:0];
			end
			ST_P2: begin
				sum_raddr = child_r;
				lz_raddr  = child_r[LA_W-1:0];
			end
			ST_C0: begin
				sum_raddr = node_q;
				lz_raddr  = node_q[LA_W-1:0];
			end
			ST_U0: begin
				sum_raddr = child_l;
			end
			ST_U1: begin
				sum_raddr = child_r;
			end
			default: begin
			end
		endcase
	end

	// Write-backs.
	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = '0;
		sum_wdata = '0;
		lz_we     = 1'b0;
		lz_waddr  = '0;
		lz_wdata  = '0;
		case (state_q)
			ST_CLR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_q;
				lz_we     = ~clr_q[NA_W-1];
				lz_waddr  = clr_q[LA_W-1:0];
			end
			ST_P1: begin
				// The parent's pending work is handed on, so it is cleared.
				lz_we    = ~lz_zero;
				lz_waddr = node_q[LA_W-1:0];
			end
			ST_P2: begin
				sum_we         = 1'b1;
				sum_waddr      = child_l;
				sum_wdata      = sum_rdata + lpars_pkg::prog_sum(a_q, d_q, child_h);
				lz_we          = (child_h != '0);
				lz_waddr       = child_l[LA_W-1:0];
				lz_wdata.start = lz_rdata.start + a_q;
				lz_wdata.count = lz_rdata.count + d_q;
			end
			ST_P3: begin
				sum_we         = 1'b1;
				sum_waddr      = child_r;
				sum_wdata      = sum_rdata + lpars_pkg::prog_sum(ar_q, d_q, child_h);
				lz_we          = (child_h != '0);
				lz_waddr       = child_r[LA_W-1:0];
				lz_wdata.start = lz_rdata.start + ar_q;
				lz_wdata.count = lz_rdata.count + d_q;
			end
			ST_C1: begin
				if (func_q == lpars_pkg::FUNC_LOAD) begin
					sum_we    = 1'b1;
					sum_waddr = node_q;
					sum_wdata = value_q;
				end else if (func_q == lpars_pkg::FUNC_ADD) begin
					sum_we         = 1'b1;
					sum_waddr      = node_q;
					sum_wdata      = sum_rdata
						+ lpars_pkg::prog_sum(a_add, CNT_W'(1), lvl_q);
					lz_we          = (lvl_q != '0);
					lz_waddr       = node_q[LA_W-1:0];
					lz_wdata.start = lz_rdata.start + a_add;
					lz_wdata.count = lz_rdata.count + CNT_W'(1);
				end
			end
			ST_U2: begin
				sum_we    = 1'b1;
				sum_waddr = node_q;
				sum_wdata = sl_q + sum_rdata;
			end
			default: begin
			end
		endcase
	end

	// Sequencer. Reset clears the control state; the payload registers are
	// always loaded before they are used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			side_q      <= 1'b0;
			lvl_q       <= '0;
			step_done_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + NA_W'(1);
					if (clr_q == NA_W'(2 * lpars_pkg::N_ELEMS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						func_q      <= func;
						value_q     <= {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
						ql_q        <= li_ext;
						l0_q        <= BND_W'(lpars_pkg::N_ELEMS) + li_ext;
						acc_q       <= '0;
						side_q      <= 1'b0;
						lvl_q       <= LVL_W'(lpars_pkg::LOG_N);
						step_done_q <= 1'b0;
						unique case (func)
							lpars_pkg::FUNC_LOAD: begin
								r0_q <= BND_W'(lpars_pkg::N_ELEMS) + li_ext + BND_W'(1);
								if (li_ok) begin
									state_q <= ST_PSEL;
								end
							end
							lpars_pkg::FUNC_ADD: begin
								r0_q <= BND_W'(lpars_pkg::N_ELEMS) + ri_clamped + BND_W'(1);
								if (range_ok) begin
									state_q <= ST_PSEL;
								end
							end
							lpars_pkg::FUNC_QUERY: begin
								r0_q    <= BND_W'(lpars_pkg::N_ELEMS) + ri_clamped + BND_W'(1);
								state_q <= range_ok ? ST_PSEL : ST_DONE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PSEL: begin
					if (path_cond && !step_done_q) begin
						node_q  <= path_node;
						state_q <= ST_P0;
					end else begin
						step_done_q <= 1'b0;
						if (!side_q) begin
							side_q <= 1'b1;
						end else begin
							side_q <= 1'b0;
							if (lvl_q == LVL_W'(1)) begin
								lvl_q   <= '0;
								l_q     <= l0_q;
								r_q     <= r0_q;
								state_q <= ST_CSEL;
							end else begin
								lvl_q <= lvl_q - LVL_W'(1);
							end
						end
					end
				end
				ST_P0: begin
					state_q <= ST_P1;
				end
				ST_P1: begin
					if (lz_zero) begin
						step_done_q <= 1'b1;
						state_q     <= ST_PSEL;
					end else begin
						a_q     <= lz_rdata.start;
						d_q     <= lz_rdata.count;
						ar_q    <= lz_rdata.start
							+ ({{(SUM_W-CNT_W){1'b0}}, lz_rdata.count} << child_h);
						state_q <= ST_P2;
					end
				end
				ST_P2: begin
					state_q <= ST_P3;
				end
				ST_P3: begin
					step_done_q <= 1'b1;
					state_q     <= ST_PSEL;
				end
				ST_CSEL: begin
					if (l_q < r_q) begin
						if (l_q[0]) begin
							node_q  <= l_q[NA_W-1:0];
							l_q     <= l_q + BND_W'(1);
							state_q <= ST_C0;
						end else if (r_q[0]) begin
							node_q  <= r_m1[NA_W-1:0];
							r_q     <= r_m1;
							state_q <= ST_C0;
						end else begin
							l_q   <= l_q >> 1;
							r_q   <= r_q >> 1;
							lvl_q <= lvl_q + LVL_W'(1);
						end
					end else if (func_q == lpars_pkg::FUNC_QUERY) begin
						state_q <= ST_DONE;
					end else begin
						lvl_q       <= LVL_W'(1);
						side_q      <= 1'b0;
						step_done_q <= 1'b0;
						state_q     <= ST_USEL;
					end
				end
				ST_C0: begin
					state_q <= ST_C1;
				end
				ST_C1: begin
					if (func_q == lpars_pkg::FUNC_QUERY) begin
						acc_q <= acc_q + sum_rdata;
					end
					state_q <= ST_CSEL;
				end
				ST_USEL: begin
					if (path_cond && !step_done_q) begin
						node_q  <= path_node;
						state_q <= ST_U0;
					end else begin
						step_done_q <= 1'b0;
						if (!side_q) begin
							side_q <= 1'b1;
						end else begin
							side_q <= 1'b0;
							if (lvl_q == LVL_W'(lpars_pkg::LOG_N)) begin
								state_q <= ST_IDLE;
							end else begin
								lvl_q <= lvl_q + LVL_W'(1);
							end
						end
					end
				end
				ST_U0: begin
					state_q <= ST_U1;
				end
				ST_U1: begin
					sl_q    <= sum_rdata;
					state_q <= ST_U2;
				end
				ST_U2: begin
					step_done_q <= 1'b1;
					state_q     <= ST_USEL;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: filled at the end of a query, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			range_sum_q <= acc_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

	lpars_ram #(
		.WIDTH(SUM_W),
		.DEPTH(2 * lpars_pkg::N_ELEMS)
	) u_sum_ram (
		.clk  (clk),
		.we   (sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.raddr(sum_raddr),
		.rdata(sum_rdata)
	);

	lpars_ram #(
		.WIDTH($bits(lpars_pkg::lazy_t)),
		.DEPTH(lpars_pkg::N_ELEMS)
	) u_lazy_ram (
		.clk  (clk),
		.we   (lz_we),
		.waddr(lz_waddr),
		.wdata(lz_wdata),
		.raddr(lz_raddr),
		.rdata(lz_rdata)
	);

`ifndef SYNTHESIS
	// A result only ever appears at the end of a query.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the query end");

	// In the covering step, pending work is only stored on internal nodes, and only by an add.
	a_lazy_internal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C1 && lz_we) |-> (lvl_q != '0 && func_q == lpars_pkg::FUNC_ADD))
		else $error("pending write on a leaf or by a non-add");

	// An accepted query always leaves idle, so it is bound to give a result.
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func == lpars_pkg::FUNC_QUERY)
		|=> (state_q != ST_IDLE && state_q != ST_CLR))
		else $error("accepted query dropped");
`endif

endmodule

// ===== test/lazy_progression_add_range_sum_tb.sv =====
// Self-checking testbench for the progression-add range-sum tree. It keeps a
// flat array as the model and needs only lpars_pkg and the top level.
`timescale 1ns / 100ps

module lazy_progression_add_range_sum_tb;

	// Cycles with no transfer on either channel before the run is given up.
	// This covers the clearing pass after reset, the longest walk and a long run
	// of receiver stalls, several times over.
	localparam int STALL_LIMIT = 20000;

	// The one operation code that the block ignores.
	localparam logic [lpars_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic [lpars_pkg::FUNC_W-1:0]        func;
	logic [lpars_pkg::IDX_W-1:0]         left_index;
	logic [lpars_pkg::IDX_W-1:0]         right_index;
	logic signed [lpars_pkg::VAL_W-1:0]  value;
	logic                                out_valid;
	logic                                out_stall;
	logic signed [lpars_pkg::SUM_W-1:0]  range_sum;

	// The model is the element array itself. Range sums are linear, so a flat
	// array wrapping at 64 bits gives the same answers as the lazy tree.
	logic [lpars_pkg::SUM_W-1:0] elem_store [lpars_pkg::N_ELEMS];
	logic [lpars_pkg::SUM_W-1:0] sum_queue [$];

	int  n_errors;
	int  n_ops;
	int  n_sums;
	bit  quiet;
	int  idle_cycles;

	lazy_progression_add_range_sum DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.left_index (left_index),
		.right_index(right_index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.range_sum  (range_sum)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string what);
		n_errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Apply one accepted operation to the model and note any expected sum.
	task automatic model_apply(input logic [lpars_pkg::FUNC_W-1:0] f,
			input logic [lpars_pkg::IDX_W-1:0] l, input logic [lpars_pkg::IDX_W-1:0] r,
			input logic signed [lpars_pkg::VAL_W-1:0] v);
		logic [lpars_pkg::SUM_W-1:0] v64;
		logic [lpars_pkg::SUM_W-1:0] acc;
		v64 = {{(lpars_pkg::SUM_W-lpars_pkg::VAL_W){v[lpars_pkg::VAL_W-1]}}, v};
		acc = '0;
		case (f)
			lpars_pkg::FUNC_LOAD: begin
				elem_store[l] = v64;
			end
			lpars_pkg::FUNC_ADD: begin
				for (int i = l; i <= r; i++)
					elem_store[lpars_pkg::IDX_W'(i)] += v64 + lpars_pkg::SUM_W'(i - l);
			end
			lpars_pkg::FUNC_QUERY: begin
				for (int i = l; i <= r; i++)
					acc += elem_store[lpars_pkg::IDX_W'(i)];
				sum_queue.push_back(acc);
			end
			default: ;
		endcase
	endtask

	// Offer one operation and hold it until it is accepted. The stall is looked
	// at on the falling edge, where every output has settled.
	task automatic send_op(input logic [lpars_pkg::FUNC_W-1:0] f,
			input logic [lpars_pkg::IDX_W-1:0] l, input logic [lpars_pkg::IDX_W-1:0] r,
			input logic signed [lpars_pkg::VAL_W-1:0] v);
		bit taken;
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		left_index  <= l;
		right_index <= r;
		value       <= v;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		model_apply(f, l, r, v);
		n_ops++;
	endtask

	// Receiver: stall at random except during the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
		end
	end

	// Result checker: each sum transfer is matched against the oldest
	// expectation.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sum_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected range_sum %0d", range_sum));
			end else begin
				if (range_sum !== sum_queue[0])
					report_mismatch($sformatf("range_sum %0d, expected %0d",
						range_sum, $signed(sum_queue[0])));
				void'(sum_queue.pop_front());
				n_sums++;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("lazy_progression_add_range_sum_tb NOT OK");
				$finish;
			end
		end
	end

	// Extreme values, the ends of the array, empty ranges and the unused code.
	task automatic test_directed();
		send_op(lpars_pkg::FUNC_QUERY, 0, 1023, 0);
		send_op(lpars_pkg::FUNC_LOAD, 0, 0, 32'sh7fffffff);
		send_op(lpars_pkg::FUNC_LOAD, 1023, 0, 32'sh80000000);
		send_op(lpars_pkg::FUNC_QUERY, 0, 0, 0);
		send_op(lpars_pkg::FUNC_QUERY, 1023, 1023, 0);
		send_op(lpars_pkg::FUNC_QUERY, 0, 1023, 0);
		send_op(lpars_pkg::FUNC_ADD, 0, 1023, 32'sh7fffffff);
		send_op(lpars_pkg::FUNC_ADD, 0, 1023, 32'sh80000000);
		send_op(lpars_pkg::FUNC_QUERY, 0, 1023, 0);
		send_op(lpars_pkg::FUNC_QUERY, 1, 1022, 0);
		send_op(lpars_pkg::FUNC_ADD, 500, 499, 1234);
		send_op(lpars_pkg::FUNC_QUERY, 500, 499, 0);
		send_op(lpars_pkg::FUNC_QUERY, 1023, 0, 0);
		send_op(FUNC_UNUSED, 7, 9, -1);
		send_op(lpars_pkg::FUNC_QUERY, 0, 1023, 0);
		send_op(lpars_pkg::FUNC_ADD, 511, 512, -1);
		send_op(lpars_pkg::FUNC_LOAD, 512, 3, -5);
		send_op(lpars_pkg::FUNC_QUERY, 510, 513, 0);
		send_op(lpars_pkg::FUNC_ADD, 1023, 1023, 32'sh7fffffff);
		send_op(lpars_pkg::FUNC_QUERY, 1020, 1023, 0);
	endtask

	// Random mix with a quiet stretch in the middle where neither side idles.
	task automatic test_random(input int count);
		logic [lpars_pkg::FUNC_W-1:0]       f;
		logic [lpars_pkg::IDX_W-1:0]        l;
		logic [lpars_pkg::IDX_W-1:0]        r;
		logic signed [lpars_pkg::VAL_W-1:0] v;
		int                                 pick;
		for (int k = 0; k < count; k++) begin
			quiet = (k >= count / 3) && (k < count / 2);
			pick = $urandom_range(99);
			f = (pick < 30) ? lpars_pkg::FUNC_LOAD : (pick < 62) ? lpars_pkg::FUNC_ADD :
				(pick < 97) ? lpars_pkg::FUNC_QUERY : FUNC_UNUSED;
			l = lpars_pkg::IDX_W'($urandom);
			r = lpars_pkg::IDX_W'($urandom);
			if ($urandom_range(3) == 0 && l > r) begin
				l ^= r;
				r ^= l;
				l ^= r;
			end
			case ($urandom_range(3))
				0: v = $urandom;
				1: v = $urandom_range(15) - 8;
				2: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
				default: v = $urandom_range(1000);
			endcase
			send_op(f, l, r, v);
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = lpars_pkg::FUNC_LOAD;
		left_index  = '0;
		right_index = '0;
		value       = '0;
		quiet       = 1'b0;
		n_errors    = 0;
		n_ops       = 0;
		n_sums      = 0;
		idle_cycles = 0;
		foreach (elem_store[i])
			elem_store[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(900);
		in_valid <= 1'b0;

		while (sum_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Run covered %0d operations (loads, progression adds, queries, unused code)",
			n_ops);
		$display("and checked %0d range sums; %0d mismatches.", n_sums, n_errors);
		if (n_errors == 0) begin
			$display("lazy_progression_add_range_sum_tb OK");
		end else begin
			$display("lazy_progression_add_range_sum_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lpars_pkg.sv
hw/rtl/lpars_ram.sv
hw/rtl/lazy_progression_add_range_sum.sv
test/lazy_progression_add_range_sum_tb.sv
